// ----- rtl/core/lru_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants and the command and status types that join the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

	// Default sizes for the top-level parameters.
	localparam int FRAMES_MAX_DEF = 8;
	localparam int PAGE_BITS_DEF  = 16;
	localparam int STAMP_BITS_DEF = 32;

	// Fixed field widths.
	localparam int CFG_W   = 4;
	localparam int SLOT_W  = 3;
	localparam int EVICT_W = 16;
	localparam int FAULT_W = 32;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Register map, as register indexes.
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	// Reset value of the frame count register.
	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the reference and start a search
		logic issue;   // read the next frame entry
		logic commit;  // update the table and load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic issue_last;  // the current read is the last active frame
		logic out_free;    // the result register can take a new result
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/lru_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences one reference: capture, frame scan, pipeline drain and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  lru_pkg::dp_sts_t sts,
	output lru_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Input is taken only while no reference is in progress.
	assign in_stall = (state_q != ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lru_dp.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Frame tables, the scan pipeline with hit and minimum search, the reference
// clock, the fault counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_dp #(
	parameter int FRAMES_MAX = lru_pkg::FRAMES_MAX_DEF,
	parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lru_pkg::STAMP_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  lru_pkg::dp_cmd_t                cmd,
	output lru_pkg::dp_sts_t                sts,
	input  wire [lru_pkg::CFG_W-1:0]        frames_in_use,
	input  wire [PAGE_BITS-1:0]             page_number,
	input  wire                             last_ref,
	input  wire                             out_stall,
	output logic                            out_valid,
	output logic                            hit,
	output logic [lru_pkg::SLOT_W-1:0]      frame_slot,
	output logic                            evicted_valid,
	output logic [lru_pkg::EVICT_W-1:0]     evicted_page,
	output logic [lru_pkg::FAULT_W-1:0]     fault_total
);

	localparam int IDX_W = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;

	// Frame tables; an entry is meaningful only while its valid bit is set.
	logic [PAGE_BITS-1:0]  page_mem  [FRAMES_MAX];
	logic [STAMP_BITS-1:0] stamp_mem [FRAMES_MAX];
	logic [FRAMES_MAX-1:0] valid_q;

	// Captured reference.
	logic [PAGE_BITS-1:0]  page_q;
	logic                  last_q;
	logic [IDX_W-1:0]      nm1_q;
	logic [IDX_W-1:0]      nm1_d;

	// Scan pipeline.
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic [PAGE_BITS-1:0]  rd_page_s1;
	logic [STAMP_BITS-1:0] rd_stamp_s1;
	logic                  rd_valid_s1;
	logic [STAMP_BITS-1:0] eff_stamp;
	logic                  hit_now;
	logic                  min_now;

	// Search results.
	logic                  hit_found_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [IDX_W-1:0]      min_idx_q;
	logic [STAMP_BITS-1:0] min_stamp_q;
	logic [PAGE_BITS-1:0]  min_page_q;
	logic                  min_valid_q;

	// Counters.
	logic [STAMP_BITS-1:0]      clock_q;
	logic [lru_pkg::FAULT_W-1:0] fault_q;
	logic [lru_pkg::FAULT_W-1:0] fault_next;
	logic [IDX_W-1:0]           slot_sel;

	// Result register.
	logic                        out_valid_q;
	logic                        out_hit_q;
	logic [lru_pkg::SLOT_W-1:0]  out_slot_q;
	logic                        out_ev_valid_q;
	logic [lru_pkg::EVICT_W-1:0] out_ev_page_q;
	logic [lru_pkg::FAULT_W-1:0] out_fault_q;

	// Active frame count minus one: zero counts as one, larger values clamp.
	always_comb begin
		if (frames_in_use == '0) begin
			nm1_d = '0;
		end else if (int'(frames_in_use) > FRAMES_MAX) begin
			nm1_d = IDX_W'(FRAMES_MAX - 1);
		end else begin
			nm1_d = IDX_W'(frames_in_use - lru_pkg::CFG_W'(1));
		end
	end

	// Capture the reference at the start of a transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page_number;
			last_q <= last_ref;
			nm1_q  <= nm1_d;
		end
	end

	// Read address counter and compare-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.issue) begin
				cmp_idx_s1 <= rd_idx_q;
				rd_idx_q   <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	assign sts.issue_last = (rd_idx_q == nm1_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// Frame to update: the hit frame, or the victim on a fault.
	assign slot_sel = hit_found_q ? hit_idx_q : min_idx_q;

	// Page table: written on a fault, read one entry per cycle during the scan.
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_found_q) begin
			page_mem[slot_sel] <= page_q;
		end
		rd_page_s1 <= page_mem[rd_idx_q];
	end

	// Stamp table: written on every commit.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stamp_mem[slot_sel] <= clock_q;
		end
		rd_stamp_s1 <= stamp_mem[rd_idx_q];
	end

	// Valid bits, read in step with the tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[rd_idx_q];
			if (cmd.commit) begin
				if (last_q) begin
					valid_q <= '0;
				end else if (!hit_found_q) begin
					valid_q[slot_sel] <= 1'b1;
				end
			end
		end
	end

	// An empty frame counts as stamp zero.
	assign eff_stamp = rd_valid_s1 ? rd_stamp_s1 : '0;
	assign hit_now   = !hit_found_q && rd_valid_s1 && (rd_page_s1 == page_q);
	assign min_now   = (cmp_idx_s1 == '0) || (eff_stamp < min_stamp_q);

	// First matching frame wins the hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q <= 1'b0;
		end else if (cmd.load) begin
			hit_found_q <= 1'b0;
		end else if (cmp_vld_s1 && hit_now) begin
			hit_found_q <= 1'b1;
		end
	end

	// Hit index and the running minimum; strict compare keeps the lowest index.
	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (hit_now) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (min_now) begin
				min_idx_q   <= cmp_idx_s1;
				min_stamp_q <= eff_stamp;
				min_page_q  <= rd_page_s1;
				min_valid_q <= rd_valid_s1;
			end
		end
	end

	// Saturating fault count including this reference.
	assign fault_next = (!hit_found_q && (fault_q != '1)) ?
		fault_q + lru_pkg::FAULT_W'(1) : fault_q;

	// Reference clock and fault counter; a last reference clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			fault_q <= '0;
		end else if (cmd.load) begin
			if (clock_q != '1) begin
				clock_q <= clock_q + STAMP_BITS'(1);
			end
		end else if (cmd.commit) begin
			if (last_q) begin
				clock_q <= '0;
				fault_q <= '0;
			end else begin
				fault_q <= fault_next;
			end
		end
	end

	// Result valid: set on commit, cleared once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q      <= hit_found_q;
			out_slot_q     <= lru_pkg::SLOT_W'(slot_sel);
			out_ev_valid_q <= !hit_found_q && min_valid_q;
			out_ev_page_q  <= (!hit_found_q && min_valid_q) ?
				lru_pkg::EVICT_W'(min_page_q) : '0;
			out_fault_q    <= fault_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign frame_slot    = out_slot_q;
	assign evicted_valid = out_ev_valid_q;
	assign evicted_page  = out_ev_page_q;
	assign fault_total   = out_fault_q;

	// A commit never overwrites a result that is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit while result register is held");

	// The compare stage only sees active frames.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (cmp_idx_s1 <= nm1_q))
		else $error("compare index beyond active frames");

	// A result is never both a hit and an eviction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_ev_valid_q))
		else $error("hit result reports an eviction");

	// A fault fills its frame, so the frame is valid afterwards.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !hit_found_q && !last_q) |=> valid_q[$past(min_idx_q)])
		else $error("faulted frame not marked valid");

endmodule

`default_nettype wire

// ----- rtl/core/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
// Each page reference passes from acceptance through a scan of n frames,
// where n is the number of active frames (the frames_in_use register, with
// zero read as one and values above FRAMES_MAX clamped), then a drain of
// the compare stage and a commit into the output register. The scan sets
// the pace: the page and stamp tables are read one frame per cycle through a
// registered read port, and the hit search and the least-recently-used
// search share that single pass. The next reference is accepted in the
// cycle after the commit. The commit waits while the output register holds
// a stalled result, and the input stays stalled for that time. A new
// reference is accepted while a finished result waits in the output
// register. No clearing pass is needed after reset.
`default_nettype none

module lru_page_replacement #(
	parameter int FRAMES_MAX = lru_pkg::FRAMES_MAX_DEF,
	parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lru_pkg::STAMP_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [lru_pkg::APB_AW-1:0]    paddr,
	input  wire [lru_pkg::APB_DW-1:0]    pwdata,
	output logic [lru_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	// Reference channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [PAGE_BITS-1:0]          page_number,
	input  wire                          last_ref,
	// Result channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         hit,
	output logic [lru_pkg::SLOT_W-1:0]   frame_slot,
	output logic                         evicted_valid,
	output logic [lru_pkg::EVICT_W-1:0]  evicted_page,
	output logic [lru_pkg::FAULT_W-1:0]  fault_total
);

	logic [lru_pkg::CFG_W-1:0] frames_in_use_q;
	logic                      reg_sel;
	lru_pkg::dp_cmd_t          cmd;
	lru_pkg::dp_sts_t          sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == lru_pkg::REG_FRAMES_IN_USE);

	// Frame count register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lru_pkg::FRAMES_IN_USE_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			frames_in_use_q <= pwdata[lru_pkg::CFG_W-1:0];
		end
	end

	// Register read-back.
	assign prdata = reg_sel ? lru_pkg::APB_DW'(frames_in_use_q) : '0;

	lru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lru_dp #(
		.FRAMES_MAX (FRAMES_MAX),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.frames_in_use (frames_in_use_q),
		.page_number   (page_number),
		.last_ref      (last_ref),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.hit           (hit),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

endmodule

`default_nettype wire
